// ===== design/brlm_pkg.sv =====
// shared constants and control types for the block rms level meter
package brlm_pkg;

   localparam int BLOCK_SAMPLES = 512;
   localparam int FRACTION_BITS = 8;
   localparam int SAMPLE_SHIFT  = 8;

   localparam int WORD_W   = 32;
   localparam int SAMPLE_W = WORD_W - SAMPLE_SHIFT;
   localparam int SQ_W     = 2 * SAMPLE_W;
   localparam int SUM_W    = 56;
   localparam int CNT_W    = $clog2(BLOCK_SAMPLES + 1);
   localparam int MEAN_W   = 48;
   localparam int RAD_W    = MEAN_W + 2 * FRACTION_BITS;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int RMS_W    = 32;
   localparam int OCNT_W   = 10;
   localparam int ITER_W   = $clog2(SUM_W);

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic square;
      logic accum;
      logic div_step;
      logic prep;
      logic sqrt_step;
      logic out_load;
   } brlm_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic close;
      logic out_free;
   } brlm_sts_type;

endpackage

// ===== design/brlm_ctrl.sv =====
// sequencing state machine for the block rms level meter
module brlm_ctrl
   import brlm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  brlm_sts_type sts,
   output brlm_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQUARE = 3'd1;
   localparam logic [2:0] S_ACCUM  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_PREP   = 3'd4;
   localparam logic [2:0] S_SQRT   = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            if (sts.close) begin
               iter_in  = ITER_W'(SUM_W - 1);
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (iter_ff == '0) begin
               state_in = S_PREP;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            iter_in  = ITER_W'(ROOT_W - 1);
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (iter_ff == '0) begin
               state_in = S_OUT;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

// ===== design/brlm_dp.sv =====
// accumulator, serial divider, serial square root and output register
module brlm_dp
   import brlm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [WORD_W-1:0] req_sample_word,
   input  logic                     req_block_end,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic        [RMS_W-1:0]  rsp_rms_level,
   output logic        [OCNT_W-1:0] rsp_sample_count,
   input  brlm_cmd_type             cmd,
   output brlm_sts_type             sts
);

   logic [SAMPLE_W-1:0] sample_ff;
   logic                end_ff;
   logic [SQ_W-1:0]     sq_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [SUM_W-1:0]    quo_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [CNT_W-1:0]    div_ff;
   logic [RAD_W-1:0]    rad_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [ROOT_W+1:0]   srem_ff;
   logic                rsp_valid_ff;
   logic [RMS_W-1:0]    rms_ff;
   logic [OCNT_W-1:0]   ocnt_ff;

   logic [SAMPLE_W-1:0]     mag;
   logic [SUM_W:0]          sum_wide;
   logic [SUM_W-1:0]        sum_sat;
   logic [CNT_W-1:0]        count_inc;
   logic [CNT_W:0]          rem_sh;
   logic [CNT_W:0]          rem_diff;
   logic                    div_ge;
   logic [ROOT_W+1:0]       srem_sh;
   logic [ROOT_W+1:0]       trial;
   logic [ROOT_W+1:0]       srem_diff;
   logic                    sqrt_ge;
   logic [CNT_W+OCNT_W-1:0] count_ext;

   // magnitude of the 24-bit sample; the most negative value maps to 2^23
   assign mag = sample_ff[SAMPLE_W-1] ? (~sample_ff + 1'b1) : sample_ff;

   // saturating accumulate
   assign sum_wide  = {1'b0, sum_ff} + (SUM_W+1)'(sq_ff);
   assign sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   assign count_inc = count_ff + 1'b1;

   assign sts.close    = end_ff | (count_inc == CNT_W'(BLOCK_SAMPLES));
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   // restoring division, one quotient bit per step
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge   = (rem_sh >= {1'b0, div_ff});
   assign rem_diff = rem_sh - {1'b0, div_ff};

   // restoring square root, one root bit per step
   assign srem_sh   = {srem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign sqrt_ge   = (srem_sh >= trial);
   assign srem_diff = srem_sh - trial;

   assign count_ext = {{OCNT_W{1'b0}}, div_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample_word[WORD_W-1:SAMPLE_SHIFT];
         end_ff    <= req_block_end;
      end
      if (cmd.square) begin
         sq_ff <= SQ_W'(mag) * SQ_W'(mag);
      end
      if (cmd.accum && sts.close) begin
         quo_ff <= sum_sat;
         div_ff <= count_inc;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], div_ge};
         rem_ff <= div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      end
      if (cmd.prep) begin
         rad_ff  <= RAD_W'(quo_ff[MEAN_W-1:0]) << (2 * FRACTION_BITS);
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= rad_ff << 2;
         root_ff <= {root_ff[ROOT_W-2:0], sqrt_ge};
         srem_ff <= sqrt_ge ? srem_diff : srem_sh;
      end
      if (cmd.out_load) begin
         rms_ff  <= RMS_W'(root_ff);
         ocnt_ff <= count_ext[OCNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accum) begin
            if (sts.close) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_sat;
               count_ff <= count_inc;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rms_level    = rms_ff;
   assign rsp_sample_count = ocnt_ff;

endmodule

// ===== design/block_rms_level_meter.sv =====
// top level of the block rms level meter
//
// req channel: one word per 32-bit left-aligned microphone sample plus a
//   block_end flag; the top 24 bits are taken as a signed sample
// rsp channel: one word per finished block, the rms level with 8 fraction
//   bits and the number of samples in that block
// a block closes on block_end or when it reaches BLOCK_SAMPLES samples
// sample flow: a sample that does not close a block passes through accept,
//   square and accumulate; a closing sample adds a serial divide, a setup
//   step, a serial square root and an output load before the next word can
//   be accepted
// result: rsp_valid rises with the output load after the closing word; the
//   load waits while the previous result is still held in the output register
// the serial divider and square-root unit set the closing-block time
// reset (synchronous, active high) clears the running sum, the count and
//   the output valid; no result is pending afterwards
// a stalled receiver holds the rsp word in the output register; the meter
//   keeps accepting samples and only waits if a second block finishes
//   before the first result is taken
module block_rms_level_meter
   import brlm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_sample_word,
   input  logic                     req_block_end,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic        [RMS_W-1:0]  rsp_rms_level,
   output logic        [OCNT_W-1:0] rsp_sample_count
);

   brlm_cmd_type cmd;
   brlm_sts_type sts;

   // sequencer: sample intake, divide and root iteration counts
   brlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and the output register
   brlm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_sample_word  (req_sample_word),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_sample_count (rsp_sample_count),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
